// ----- sv/bmp_rle8_run_encoder_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the BMP RLE8 run encoder
// Shared concurrent-assertion wrappers used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE8_RUN_ENCODER_TOP_MACROS_SVH
`define BMP_RLE8_RUN_ENCODER_TOP_MACROS_SVH

// Checked on every rising edge of aclk while aresetn is high.
`define BRLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define BRLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- sv/brle_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8 run encoder package
// Types and constants shared by the run encoder modules.
// ----------------------------------------------------------------------------
package brle_pkg;

    localparam logic [7:0]  RUN_MAX         = 8'd255;
    localparam logic [7:0]  ESC_EOL         = 8'h00;
    localparam logic [7:0]  ESC_EOI         = 8'h01;
    localparam logic [15:0] ROW_WIDTH_RESET = 16'd640;
    localparam int          MAX_PAIRS       = 3;

    // Register index as decoded from paddr[2].
    localparam logic        REG_ROW_WIDTH   = 1'b0;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] value;
        logic       last;
    } pair_t;

    typedef struct packed {
        logic [7:0]  run_pixel;
        logic [7:0]  run_length;
        logic [15:0] column;
    } run_state_t;

    // Everything one pixel produces: up to three pairs and the next state.
    typedef struct packed {
        pair_t [MAX_PAIRS-1:0] pairs;
        logic [1:0]            npairs;
        run_state_t            state;
    } step_result_t;

    // Request from the pixel stage to the pair buffer.
    typedef struct packed {
        logic                  load;
        pair_t [MAX_PAIRS-1:0] pairs;
        logic [1:0]            npairs;
    } buf_load_t;

endpackage

// ----- sv/brle_step.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8 run step logic
// Works out the pairs one pixel closes and the run state it leaves behind.
// ----------------------------------------------------------------------------
module brle_step (
    input  logic [7:0]            pixel,
    input  logic                  end_of_image,
    input  logic [15:0]           row_width,
    input  brle_pkg::run_state_t  state,
    output brle_pkg::step_result_t result
);
    import brle_pkg::*;

    logic        match;
    logic        close_old;
    logic [7:0]  new_len;
    logic        hit_max;
    logic [7:0]  after_len;
    logic        row_end;
    logic        esc;
    logic        flush;
    pair_t [3:0] cand;
    logic  [3:0] cand_vld;
    logic  [1:0] n;

    always_comb begin
        match     = (state.run_length != 8'd0) && (state.run_pixel == pixel);
        close_old = (state.run_length != 8'd0) && !match;
        new_len   = match ? (state.run_length + 8'd1) : 8'd1;
        hit_max   = (new_len == RUN_MAX);
        after_len = hit_max ? 8'd0 : new_len;
        row_end   = (state.column == (row_width - 16'd1));
        esc       = end_of_image || row_end;
        flush     = esc && (after_len != 8'd0);

        // Candidates in output order; at most three of them are ever set.
        cand[0]     = '{count: state.run_length, value: state.run_pixel, last: 1'b0};
        cand_vld[0] = close_old;
        cand[1]     = '{count: RUN_MAX, value: pixel, last: 1'b0};
        cand_vld[1] = hit_max;
        cand[2]     = '{count: after_len, value: pixel, last: 1'b0};
        cand_vld[2] = flush;
        cand[3]     = '{count: 8'd0, value: end_of_image ? ESC_EOI : ESC_EOL, last: 1'b0};
        cand_vld[3] = esc;
    end

    always_comb begin
        result.pairs = '0;
        n = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cand_vld[i] && (n < 2'd3)) begin
                result.pairs[n] = cand[i];
                n = n + 2'd1;
            end
        end
        result.npairs = n;
        if (n != 2'd0) begin
            result.pairs[n - 2'd1].last = 1'b1;
        end

        if (end_of_image) begin
            result.state.run_pixel  = 8'd0;
            result.state.run_length = 8'd0;
            result.state.column     = 16'd0;
        end else if (row_end) begin
            result.state.run_pixel  = pixel;
            result.state.run_length = 8'd0;
            result.state.column     = 16'd0;
        end else begin
            result.state.run_pixel  = pixel;
            result.state.run_length = after_len;
            result.state.column     = state.column + 16'd1;
        end
    end

endmodule

// ----- sv/brle_pair_buf.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8 pair buffer
// Holds the pairs of one pixel and hands them out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module brle_pair_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  brle_pkg::buf_load_t  load_req,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] run_count, [15:8] run_value
    output logic                 m_tlast    // last_of_item
);
    import brle_pkg::*;

    pair_t [MAX_PAIRS-1:0] slot_reg;
    pair_t [MAX_PAIRS-1:0] slot_next;
    logic  [1:0]           cnt_reg;
    logic  [1:0]           cnt_next;
    logic                  pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    // New pairs may come in once the buffer is empty after this cycle's pop.
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign m_tdata  = {slot_reg[0].value, slot_reg[0].count};
    assign m_tlast  = slot_reg[0].last;

    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load_req.load) begin
            slot_next = load_req.pairs;
            cnt_next  = load_req.npairs;
        end else if (pop) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `include "bmp_rle8_run_encoder_top_macros.svh"

    `BRLE_ASSERT(a_load_only_when_free, load_req.load |-> can_load, "pairs loaded over pending pairs")
    `BRLE_ASSERT(a_drain_to_empty, (pop && cnt_reg == 2'd1 && !load_req.load) |=> !m_tvalid, "buffer did not drain")

endmodule

// ----- sv/bmp_rle8_run_encoder_top.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8 run encoder, top level
// Turns a stream of 8-bit palette indices into RLE8 encoded-mode pairs.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_ channel, one palette index per request in s_tdata,
// with s_tlast set on the final pixel of the image. Pairs leave on the m_
// channel: m_tdata carries run_count in its low byte and run_value in its
// high byte, and m_tlast marks the last pair caused by one pixel. A count
// of zero is an escape: value 0 ends a row, value 1 ends the image.
// The row width is written through the APB port at address 0 and resets to
// 640 pixels. The user must write it only while the encoder is idle; the
// block itself does not enforce this.
// A pixel passes through the input register and then the pair buffer before
// its first pair is on m_tdata. Pixels that produce no pair or one pair
// stream at one pixel per clock while the receiver is ready. A pixel that
// closes a run and a row can give up to three pairs, and the output port
// drains one pair per cycle while m_tready is high, so a following pixel
// with pairs waits in the input register until the last of those is taken.
// A synchronous low aresetn empties both stages and clears the run state.
// When the receiver stalls, the pair buffer keeps its pairs and the input
// register stops taking pixels once its pixel has pairs the buffer cannot take.
// ----------------------------------------------------------------------------
module bmp_rle8_run_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel
    input  logic        s_tlast,    // end_of_image
    // pair channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] run_count, [15:8] run_value
    output logic        m_tlast,    // last_of_item
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import brle_pkg::*;

    logic [15:0]  row_width_reg;
    logic         in_vld_reg;
    logic [7:0]   in_pixel_reg;
    logic         in_eoi_reg;
    run_state_t   state_reg;
    step_result_t step;
    buf_load_t    load_req;
    logic         can_load;
    logic         advance;
    logic         cfg_wr;

    // Configuration port: a single register at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROW_WIDTH);
    assign prdata = (paddr[2] == REG_ROW_WIDTH) ? {16'd0, row_width_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_wr) begin
            row_width_reg <= pwdata[15:0];
        end
    end

    brle_step u_step (
        .pixel        (in_pixel_reg),
        .end_of_image (in_eoi_reg),
        .row_width    (row_width_reg),
        .state        (state_reg),
        .result       (step)
    );

    // A pixel with no pairs only updates the run state, so it never waits
    // on the pair buffer.
    assign advance  = in_vld_reg && (can_load || (step.npairs == 2'd0));
    assign s_tready = !in_vld_reg || advance;

    assign load_req.load   = advance && (step.npairs != 2'd0);
    assign load_req.pairs  = step.pairs;
    assign load_req.npairs = step.npairs;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pixel_reg <= s_tdata;
            in_eoi_reg   <= s_tlast;
        end
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= step.state;
            end
        end
    end

    brle_pair_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_req (load_req),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `include "bmp_rle8_run_encoder_top_macros.svh"

    `BRLE_ASSERT(a_no_full_run_held, state_reg.run_length != RUN_MAX, "run of 255 left open")
    `BRLE_ASSERT(a_eoi_clear, (advance && in_eoi_reg) |=> (state_reg == '0), "state kept after eoi")
    `BRLE_ASSERT(a_reset_idle, $past(!aresetn) |-> !(m_tvalid || in_vld_reg), "busy after reset")

endmodule
